// File: rtl/core/nmea_pkg.sv
// ----------------------------------------------------------------------------
// nmea_pkg
// Types, character codes and conversion helpers for the NMEA GGA/RMC parser.
// ----------------------------------------------------------------------------
package nmea_pkg;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_RMC   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ROLE_NONE     = 3'd0,
        ROLE_LAT      = 3'd1,
        ROLE_LAT_HEMI = 3'd2,
        ROLE_LON      = 3'd3,
        ROLE_LON_HEMI = 3'd4,
        ROLE_STATUS   = 3'd5,
        ROLE_QUALITY  = 3'd6
    } t_role;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    localparam logic [23:0] E7          = 24'd10000000;
    localparam logic [31:0] MAG_MAX     = 32'h7FFF_FFFF;
    localparam logic [11:0] SAT_DEG     = 12'd215;
    localparam logic [2:0]  FRAC_DIGITS = 3'd7;
    // floor(x * RECIP_60 / 2^36) == floor(x / 60) for all x below 2^30
    localparam logic [30:0] RECIP_60    = 31'd1145324613;

    // coordinate text kept as degrees, two minute digits and a 1e-7 fraction
    typedef struct packed {
        logic        sat;
        logic [7:0]  deg;
        logic [3:0]  tens;
        logic [3:0]  ones;
        logic [23:0] frac;
    } t_coord;

    typedef struct packed {
        t_kind kind;
        logic  valid;
        logic  held;
    } t_meta;

    typedef struct packed {
        logic        sat;
        logic        neg;
        logic [31:0] deg_e7;
        logic [29:0] min_e7;
    } t_conv2;

    typedef struct packed {
        logic        sat;
        logic        neg;
        logic [31:0] deg_e7;
        logic [23:0] quot;
    } t_conv3;

    function automatic t_role field_role(t_kind kind, logic [2:0] num);
        t_role r;
        r = ROLE_NONE;
        case (kind)
            KIND_GGA: begin
                case (num)
                    3'd2:    r = ROLE_LAT;
                    3'd3:    r = ROLE_LAT_HEMI;
                    3'd4:    r = ROLE_LON;
                    3'd5:    r = ROLE_LON_HEMI;
                    3'd6:    r = ROLE_QUALITY;
                    default: r = ROLE_NONE;
                endcase
            end
            KIND_RMC: begin
                case (num)
                    3'd2:    r = ROLE_STATUS;
                    3'd3:    r = ROLE_LAT;
                    3'd4:    r = ROLE_LAT_HEMI;
                    3'd5:    r = ROLE_LON;
                    3'd6:    r = ROLE_LON_HEMI;
                    default: r = ROLE_NONE;
                endcase
            end
            default: r = ROLE_NONE;
        endcase
        return r;
    endfunction

    // integer digit: shift through the two minute digits into degrees
    function automatic t_coord coord_int_digit(t_coord c, logic [3:0] d);
        t_coord      r;
        logic [11:0] deg_x;
        r     = c;
        deg_x = {4'd0, c.deg} * 12'd10 + {8'd0, c.tens};
        if (!c.sat) begin
            if (deg_x >= SAT_DEG) begin
                r.sat = 1'b1;
            end
            r.deg  = deg_x[7:0];
            r.tens = c.ones;
            r.ones = d;
        end
        return r;
    endfunction

    function automatic t_coord coord_frac_digit(t_coord c, logic [3:0] d, logic [2:0] idx);
        t_coord      r;
        logic [23:0] w;
        logic [27:0] p;
        r = c;
        case (idx)
            3'd0:    w = 24'd1000000;
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        p      = {24'd0, d} * {4'd0, w};
        r.frac = c.frac + p[23:0];
        return r;
    endfunction

    function automatic t_conv2 conv_scale(t_coord c, logic neg);
        t_conv2      r;
        logic [6:0]  mins;
        logic [30:0] me;
        logic [31:0] de;
        mins     = {3'd0, c.tens} * 7'd10 + {3'd0, c.ones};
        me       = {24'd0, mins} * {7'd0, E7} + {7'd0, c.frac};
        de       = {24'd0, c.deg} * {8'd0, E7};
        r.sat    = c.sat;
        r.neg    = neg;
        r.deg_e7 = de;
        r.min_e7 = me[29:0];
        return r;
    endfunction

    function automatic t_conv3 conv_div(t_conv2 c);
        t_conv3      r;
        logic [60:0] p;
        p        = {31'd0, c.min_e7} * {30'd0, RECIP_60};
        r.sat    = c.sat;
        r.neg    = c.neg;
        r.deg_e7 = c.deg_e7;
        r.quot   = p[59:36];
        return r;
    endfunction

    function automatic logic [31:0] conv_final(t_conv3 c, logic valid);
        logic [32:0] mag;
        logic [31:0] m;
        logic [31:0] res;
        mag = {1'b0, c.deg_e7} + {9'd0, c.quot};
        if (c.sat || (mag > {1'b0, MAG_MAX})) begin
            m = MAG_MAX;
        end else begin
            m = mag[31:0];
        end
        res = c.neg ? (32'd0 - m) : m;
        if (!valid) begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/nmea_gga_rmc_position_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_rmc_position_parser
// Parses GGA and RMC sentences byte by byte and reports fix and position.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                            tuser
//  s_axis   in   [7:0] rx_byte                    -
//  m_axis   out  [31:0] lat_e7, [63:32] lon_e7    [1:0] kind, [2] fix_valid, [3] fix_held
//
//  one byte is taken every cycle while s_axis tready is high; the line state updates in the cycle of the beat
//  a newline result is captured, then passes scale, divide-by-60 and saturate stages
//  into the output register, each stage holding while the stages after it stall
//  s_axis tready drops only when all four result stages are full and m_axis stalls
//  synchronous reset clears the line state and the fix flag; no clearing pass
// ----------------------------------------------------------------------------
module nmea_gga_rmc_position_parser #(
    parameter int LINE_BYTES        = 128,
    parameter int COORD_FIELD_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [31:0] latitude_e7, [63:32] longitude_e7
    output logic [3:0]  o_m_axis_tuser    // [1:0] sentence_kind, [2] fix_valid, [3] fix_held
);
    import nmea_pkg::*;

    localparam int LW  = $clog2(LINE_BYTES);
    localparam int FLW = $clog2(COORD_FIELD_BYTES + 1);
    localparam logic [LW-1:0]  LINE_LAST = LW'(LINE_BYTES - 1);
    localparam logic [FLW-1:0] FLD_MAX   = FLW'(COORD_FIELD_BYTES);

    // line state
    logic [LW-1:0]  r_line_len, n_line_len;
    logic [2:0]     r_field_num, n_field_num;
    logic [FLW-1:0] r_field_len, n_field_len;
    logic [7:0]     r_first, n_first;
    logic           r_pfx_gga, n_pfx_gga;
    logic           r_pfx_rmc, n_pfx_rmc;
    logic           r_pfx_dollar, n_pfx_dollar;
    t_coord         r_lat, n_lat;
    t_coord         r_lon, n_lon;
    logic           r_lat_neg, n_lat_neg;
    logic           r_lon_neg, n_lon_neg;
    logic           r_stat_a, n_stat_a;
    logic           r_qual_ok, n_qual_ok;
    logic           r_lat_p, n_lat_p;
    logic           r_lon_p, n_lon_p;
    logic           r_fix, n_fix;
    logic           r_scan_dot, n_scan_dot;
    logic           r_scan_stop, n_scan_stop;
    logic [2:0]     r_scan_frac, n_scan_frac;

    // result pipeline
    logic   r_v1, r_v2, r_v3, r_o_valid;
    t_meta  r_s1_meta, r_s2_meta, r_s3_meta, r_o_meta;
    t_coord r_s1_lat, r_s1_lon;
    logic   r_s1_lat_neg, r_s1_lon_neg;
    t_conv2 r_s2_lat, r_s2_lon;
    t_conv3 r_s3_lat, r_s3_lon;
    logic [31:0] r_o_lat, r_o_lon;

    logic   w_o_free, w_en3, w_en2, w_en1, w_acc;
    logic   w_res_load;
    t_meta  w_res_meta;
    logic [7:0] w_c;
    logic [3:0] w_digit;
    t_kind  w_kind;
    t_role  w_role;
    logic   w_one, w_hemi_neg, w_coord_ok;
    logic   w_c_lat_p, w_c_lon_p, w_c_lat_neg, w_c_lon_neg, w_c_stat, w_c_qual;
    t_coord w_sel, w_upd;

    assign w_o_free        = !r_o_valid || i_m_axis_tready;
    assign w_en3           = !r_v3 || w_o_free;
    assign w_en2           = !r_v2 || w_en3;
    assign w_en1           = !r_v1 || w_en2;
    assign o_s_axis_tready = w_en1;
    assign w_acc           = i_s_axis_tvalid && w_en1;
    assign w_c             = i_s_axis_tdata;
    assign w_digit         = 4'(w_c - CH_ZERO);

    assign w_kind = (r_line_len < LW'(6)) ? KIND_OTHER :
                    r_pfx_gga ? KIND_GGA :
                    r_pfx_rmc ? KIND_RMC : KIND_OTHER;
    assign w_role = field_role(w_kind, r_field_num);

    // flags as they stand once the current field is closed
    assign w_one       = (r_field_len == FLW'(1));
    assign w_hemi_neg  = w_one && ((r_first == CH_S) || (r_first == CH_W));
    assign w_coord_ok  = (r_field_len != '0) && (r_field_len < FLD_MAX);
    assign w_c_lat_p   = r_lat_p || ((w_role == ROLE_LAT) && w_coord_ok);
    assign w_c_lon_p   = r_lon_p || ((w_role == ROLE_LON) && w_coord_ok);
    assign w_c_lat_neg = r_lat_neg || ((w_role == ROLE_LAT_HEMI) && w_hemi_neg);
    assign w_c_lon_neg = r_lon_neg || ((w_role == ROLE_LON_HEMI) && w_hemi_neg);
    assign w_c_stat    = r_stat_a || ((w_role == ROLE_STATUS) && w_one && (r_first == CH_A));
    assign w_c_qual    = r_qual_ok || ((w_role == ROLE_QUALITY) && (r_field_len != '0) &&
                         (r_field_len < FLW'(4)) && (r_first != CH_ZERO));

    always_comb begin
        n_line_len   = r_line_len;
        n_field_num  = r_field_num;
        n_field_len  = r_field_len;
        n_first      = r_first;
        n_pfx_gga    = r_pfx_gga;
        n_pfx_rmc    = r_pfx_rmc;
        n_pfx_dollar = r_pfx_dollar;
        n_lat        = r_lat;
        n_lon        = r_lon;
        n_lat_neg    = r_lat_neg;
        n_lon_neg    = r_lon_neg;
        n_stat_a     = r_stat_a;
        n_qual_ok    = r_qual_ok;
        n_lat_p      = r_lat_p;
        n_lon_p      = r_lon_p;
        n_fix        = r_fix;
        n_scan_dot   = r_scan_dot;
        n_scan_stop  = r_scan_stop;
        n_scan_frac  = r_scan_frac;
        w_res_load   = 1'b0;
        w_res_meta   = '0;
        w_sel        = (w_role == ROLE_LAT) ? r_lat : r_lon;
        w_upd        = w_sel;

        if (w_acc && (w_c != CH_CR)) begin
            if ((w_c == CH_LF) || (r_line_len == LINE_LAST)) begin
                if ((w_c == CH_LF) && (r_line_len != '0) && r_pfx_dollar) begin
                    w_res_load       = 1'b1;
                    w_res_meta.kind  = w_kind;
                    w_res_meta.valid = w_c_lat_p && w_c_lon_p &&
                                       (((w_kind == KIND_GGA) && w_c_qual) ||
                                        ((w_kind == KIND_RMC) && w_c_stat));
                    w_res_meta.held  = (w_kind != KIND_OTHER) ? w_res_meta.valid : r_fix;
                    n_fix            = w_res_meta.held;
                end
                // an empty line leaves everything as it is
                if ((w_c != CH_LF) || (r_line_len != '0)) begin
                    n_line_len   = '0;
                    n_field_num  = '0;
                    n_field_len  = '0;
                    n_first      = '0;
                    n_pfx_gga    = 1'b0;
                    n_pfx_rmc    = 1'b0;
                    n_pfx_dollar = 1'b0;
                    n_lat        = '0;
                    n_lon        = '0;
                    n_lat_neg    = 1'b0;
                    n_lon_neg    = 1'b0;
                    n_stat_a     = 1'b0;
                    n_qual_ok    = 1'b0;
                    n_lat_p      = 1'b0;
                    n_lon_p      = 1'b0;
                    n_scan_dot   = 1'b0;
                    n_scan_stop  = 1'b0;
                    n_scan_frac  = '0;
                end
            end else begin
                // prefix match over the first six bytes
                if (r_line_len == LW'(0)) begin
                    if (w_c == CH_DOLLAR) begin
                        n_pfx_gga    = 1'b1;
                        n_pfx_rmc    = 1'b1;
                        n_pfx_dollar = 1'b1;
                    end
                end else if (r_line_len == LW'(1)) begin
                    n_pfx_gga = r_pfx_gga && (w_c == CH_G);
                    n_pfx_rmc = r_pfx_rmc && (w_c == CH_G);
                end else if (r_line_len == LW'(2)) begin
                    n_pfx_gga = r_pfx_gga && ((w_c == CH_P) || (w_c == CH_N));
                    n_pfx_rmc = r_pfx_rmc && ((w_c == CH_P) || (w_c == CH_N));
                end else if (r_line_len == LW'(3)) begin
                    n_pfx_gga = r_pfx_gga && (w_c == CH_G);
                    n_pfx_rmc = r_pfx_rmc && (w_c == CH_R);
                end else if (r_line_len == LW'(4)) begin
                    n_pfx_gga = r_pfx_gga && (w_c == CH_G);
                    n_pfx_rmc = r_pfx_rmc && (w_c == CH_M);
                end else if (r_line_len == LW'(5)) begin
                    n_pfx_gga = r_pfx_gga && (w_c == CH_A);
                    n_pfx_rmc = r_pfx_rmc && (w_c == CH_C);
                end

                if ((w_kind != KIND_OTHER) && (r_field_num <= 3'd6)) begin
                    if ((w_c == CH_COMMA) || (w_c == CH_STAR)) begin
                        n_lat_p     = w_c_lat_p;
                        n_lon_p     = w_c_lon_p;
                        n_lat_neg   = w_c_lat_neg;
                        n_lon_neg   = w_c_lon_neg;
                        n_stat_a    = w_c_stat;
                        n_qual_ok   = w_c_qual;
                        n_field_num = r_field_num + 3'd1;
                        n_field_len = '0;
                        n_first     = '0;
                        n_scan_dot  = 1'b0;
                        n_scan_stop = 1'b0;
                        n_scan_frac = '0;
                    end else begin
                        if (r_field_len == '0) begin
                            n_first = w_c;
                        end
                        if (r_field_len != FLD_MAX) begin
                            n_field_len = r_field_len + FLW'(1);
                        end
                        if (((w_role == ROLE_LAT) || (w_role == ROLE_LON)) && !r_scan_stop) begin
                            if ((w_c >= CH_ZERO) && (w_c <= CH_NINE)) begin
                                if (!r_scan_dot) begin
                                    w_upd = coord_int_digit(w_sel, w_digit);
                                end else if (r_scan_frac < FRAC_DIGITS) begin
                                    w_upd       = coord_frac_digit(w_sel, w_digit, r_scan_frac);
                                    n_scan_frac = r_scan_frac + 3'd1;
                                end
                            end else if ((w_c == CH_DOT) && !r_scan_dot) begin
                                n_scan_dot = 1'b1;
                            end else begin
                                n_scan_stop = 1'b1;
                            end
                            if (w_role == ROLE_LAT) begin
                                n_lat = w_upd;
                            end else begin
                                n_lon = w_upd;
                            end
                        end
                    end
                end
                n_line_len = r_line_len + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len   <= '0;
            r_field_num  <= '0;
            r_field_len  <= '0;
            r_first      <= '0;
            r_pfx_gga    <= 1'b0;
            r_pfx_rmc    <= 1'b0;
            r_pfx_dollar <= 1'b0;
            r_lat        <= '0;
            r_lon        <= '0;
            r_lat_neg    <= 1'b0;
            r_lon_neg    <= 1'b0;
            r_stat_a     <= 1'b0;
            r_qual_ok    <= 1'b0;
            r_lat_p      <= 1'b0;
            r_lon_p      <= 1'b0;
            r_fix        <= 1'b0;
            r_scan_dot   <= 1'b0;
            r_scan_stop  <= 1'b0;
            r_scan_frac  <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_line_len   <= n_line_len;
            r_field_num  <= n_field_num;
            r_field_len  <= n_field_len;
            r_first      <= n_first;
            r_pfx_gga    <= n_pfx_gga;
            r_pfx_rmc    <= n_pfx_rmc;
            r_pfx_dollar <= n_pfx_dollar;
            r_lat        <= n_lat;
            r_lon        <= n_lon;
            r_lat_neg    <= n_lat_neg;
            r_lon_neg    <= n_lon_neg;
            r_stat_a     <= n_stat_a;
            r_qual_ok    <= n_qual_ok;
            r_lat_p      <= n_lat_p;
            r_lon_p      <= n_lon_p;
            r_fix        <= n_fix;
            r_scan_dot   <= n_scan_dot;
            r_scan_stop  <= n_scan_stop;
            r_scan_frac  <= n_scan_frac;
            if (w_en1) begin
                r_v1 <= w_res_load;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_o_free) begin
                r_o_valid <= r_v3;
            end
        end
    end

    // result payload: capture, scale, divide by 60, then add, saturate, sign, zero if no fix
    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_s1_meta    <= w_res_meta;
            r_s1_lat     <= r_lat;
            r_s1_lon     <= r_lon;
            r_s1_lat_neg <= w_c_lat_neg;
            r_s1_lon_neg <= w_c_lon_neg;
        end
        if (w_en2) begin
            r_s2_meta <= r_s1_meta;
            r_s2_lat  <= conv_scale(r_s1_lat, r_s1_lat_neg);
            r_s2_lon  <= conv_scale(r_s1_lon, r_s1_lon_neg);
        end
        if (w_en3) begin
            r_s3_meta <= r_s2_meta;
            r_s3_lat  <= conv_div(r_s2_lat);
            r_s3_lon  <= conv_div(r_s2_lon);
        end
        if (w_o_free) begin
            r_o_meta <= r_s3_meta;
            r_o_lat  <= conv_final(r_s3_lat, r_s3_meta.valid);
            r_o_lon  <= conv_final(r_s3_lon, r_s3_meta.valid);
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_lon, r_o_lat};
    assign o_m_axis_tuser  = {r_o_meta.held, r_o_meta.valid, r_o_meta.kind};

`ifndef SYNTHESIS
    a_other_no_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser[1:0] == KIND_OTHER)) |-> !o_m_axis_tuser[2])
        else $error("fix reported on a sentence of another kind");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2]) |-> o_m_axis_tuser[3])
        else $error("fix flag not held after a valid fix");

    a_no_fix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[2]) |-> (o_m_axis_tdata == 64'd0))
        else $error("position nonzero without a fix");

    a_prefix_dollar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pfx_dollar |-> (!r_pfx_gga && !r_pfx_rmc))
        else $error("sentence match without a leading dollar");

    a_fix_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fix != $past(r_fix)) |-> $past(w_res_load && (w_res_meta.kind != KIND_OTHER)))
        else $error("fix flag changed without a gga or rmc line");
`endif

endmodule
